@@ design/rhc_pkg.sv @@
// shared constants and helpers for the rgb to hsi converter
package rhc_pkg;

  localparam int unsigned HUE_FRAC_DEF = 6;
  localparam int unsigned ANG_BITS     = 16;
  localparam int unsigned CORDIC_STEPS = 18;
  localparam int unsigned XW           = 28;
  localparam int unsigned AW           = 26;
  localparam int unsigned ZW           = 25;
  localparam logic [16:0] SQRT3_Q16    = 17'd113512;
  localparam logic [17:0] RECIP3_Q19   = 18'd174763;
  localparam logic [16:0] SAT_TWICE    = 17'd131070;

  typedef logic signed [XW-1:0] cw_t;
  typedef logic signed [AW-1:0] ang_t;

  typedef struct packed {
    logic gray;
    logic vneg;
    logic uneg;
  } side_t;

  function automatic logic [22:0] atan_q16(input int unsigned i);
    logic [22:0] t;
    case (i)
      0:       t = 23'd2949120;
      1:       t = 23'd1740967;
      2:       t = 23'd919879;
      3:       t = 23'd466945;
      4:       t = 23'd234379;
      5:       t = 23'd117304;
      6:       t = 23'd58666;
      7:       t = 23'd29335;
      8:       t = 23'd14668;
      9:       t = 23'd7334;
      10:      t = 23'd3667;
      11:      t = 23'd1833;
      12:      t = 23'd917;
      13:      t = 23'd458;
      14:      t = 23'd229;
      15:      t = 23'd115;
      16:      t = 23'd57;
      17:      t = 23'd29;
      default: t = 23'd0;
    endcase
    return t;
  endfunction

endpackage

@@ design/rgb_to_hsi_convert.sv @@
// rgb to hsi pixel converter, eight stage pipeline
// throughput: one pixel per cycle unless a stall at the output holds the pipeline;
//   an 18 step cordic at 3 steps a stage and a 16 bit restoring divider at 4 bits a stage set the depth
// reset: synchronous active low rst_n clears all valid bits
// a stall at the output freezes every stage together
module rgb_to_hsi_convert #(
  parameter int unsigned HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // hue[14:0], saturation[30:15], intensity[46:31], zero
);
  import rhc_pkg::*;

  localparam int unsigned NST  = 8;
  localparam int unsigned SH   = ANG_BITS - HUE_FRAC_BITS;
  localparam logic [ZW-1:0] HALF   = ZW'((64'd1 << SH) >> 1);
  localparam logic [ZW-1:0] GRAY   = ZW'(64'd360 << HUE_FRAC_BITS);
  localparam logic [ZW-1:0] FULL   = ZW'(64'd360 << ANG_BITS);
  localparam logic [ZW-1:0] HALFTN = ZW'(64'd180 << ANG_BITS);
  localparam ang_t          RIGHT  = AW'(64'd90 << ANG_BITS);

  logic [NST-1:0] vld_r;
  logic           adv;

  assign adv        = !vld_r[NST-1] || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  // stage 1: channel sums, extremes and cordic start vector
  logic [7:0]        red, green, blue, mx, mn;
  logic [9:0]        sum;
  logic signed [10:0] vv;
  logic signed [8:0]  uu;
  logic [9:0]        av;
  logic [7:0]        au;
  logic [24:0]       yprod;

  assign red   = in_tdata[7:0];
  assign green = in_tdata[15:8];
  assign blue  = in_tdata[23:16];

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    sum   = 10'(red) + 10'(green) + 10'(blue);
    vv    = $signed({2'b0, red, 1'b0}) - $signed({3'b0, green}) - $signed({3'b0, blue});
    uu    = $signed({1'b0, green}) - $signed({1'b0, blue});
    av    = vv[10] ? 10'(-vv) : 10'(vv);
    au    = uu[8] ? 8'(-uu) : 8'(uu);
    yprod = 25'(au) * 25'(SQRT3_Q16);
  end

  side_t       sb_r [0:NST-2];
  cw_t         cx_r [0:6];
  cw_t         cy_r [0:6];
  ang_t        ca_r [0:6];
  logic [9:0]  a1_r [0:1];
  logic [9:0]  b1_r [0:1];
  logic [9:0]  a2_r [0:1];
  logic [9:0]  b2_r [0:1];
  logic [17:0] nint_r;
  logic [35:0] iprod_r;
  logic [19:0] p1_r, p2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0]  <= '{gray: mx == mn, vneg: vv[10], uneg: uu[8]};
      cx_r[0]  <= cw_t'({2'b0, av, 16'h0});
      cy_r[0]  <= cw_t'({3'b0, yprod});
      ca_r[0]  <= '0;
      a1_r[0]  <= 10'({mx, 1'b0}) + 10'(mx) - sum;
      b1_r[0]  <= 10'd765 - sum;
      a2_r[0]  <= sum - 10'({mn, 1'b0}) - 10'(mn);
      b2_r[0]  <= sum;
      nint_r   <= 18'(sum) * 18'd257 + 18'd1;
      for (int k = 1; k < NST - 1; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
      a1_r[1]  <= a1_r[0];
      b1_r[1]  <= b1_r[0];
      a2_r[1]  <= a2_r[0];
      b2_r[1]  <= b2_r[0];
      p1_r     <= 20'(a1_r[0]) * 20'(b2_r[0]);
      p2_r     <= 20'(a2_r[0]) * 20'(b1_r[0]);
      iprod_r  <= 36'(nint_r) * 36'(RECIP3_Q19);
    end
  end

  // cordic vectoring, three micro-rotations per stage
  for (genvar gs = 0; gs < 6; gs++) begin : g_cordic
    cw_t  x, y, xo;
    ang_t a;
    always_comb begin
      x = cx_r[gs];
      y = cy_r[gs];
      a = ca_r[gs];
      for (int j = 0; j < 3; j++) begin
        xo = x;
        if (!y[XW-1]) begin
          x = x + (y >>> (gs * 3 + j));
          y = y - (xo >>> (gs * 3 + j));
          a = a + ang_t'(atan_q16(gs * 3 + j));
        end else begin
          x = x - (y >>> (gs * 3 + j));
          y = y + (xo >>> (gs * 3 + j));
          a = a - ang_t'(atan_q16(gs * 3 + j));
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cx_r[gs+1] <= x;
        cy_r[gs+1] <= y;
        ca_r[gs+1] <= a;
      end
    end
  end

  // stage 3: pick the larger fraction, set up the divider
  logic [26:0] rm_r [0:4];
  logic [15:0] qt_r [0:4];
  logic [10:0] dd_r [0:4];
  logic        cl_r [0:4];
  logic [15:0] it_r [0:4];
  logic [9:0]  na, nb;

  always_comb begin
    if (p1_r >= p2_r) begin
      na = a1_r[1];
      nb = b1_r[1];
    end else begin
      na = a2_r[1];
      nb = b2_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rm_r[0] <= 27'(na) * 27'(SAT_TWICE) + 27'(nb);
      qt_r[0] <= '0;
      dd_r[0] <= {nb, 1'b0};
      cl_r[0] <= na >= nb;
      it_r[0] <= iprod_r[34:19];
      for (int k = 1; k < 5; k++) begin
        dd_r[k] <= dd_r[k-1];
        cl_r[k] <= cl_r[k-1];
        it_r[k] <= it_r[k-1];
      end
    end
  end

  // restoring divider, four quotient bits per stage
  for (genvar gd = 0; gd < 4; gd++) begin : g_div
    logic [26:0] rem;
    logic [15:0] q;
    always_comb begin
      rem = rm_r[gd];
      q   = qt_r[gd];
      for (int j = 0; j < 4; j++) begin
        if (rem >= (27'(dd_r[gd]) << (15 - (gd * 4 + j)))) begin
          rem = rem - (27'(dd_r[gd]) << (15 - (gd * 4 + j)));
          q[15 - (gd * 4 + j)] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rm_r[gd+1] <= rem;
        qt_r[gd+1] <= q;
      end
    end
  end

  // final stage: quadrant placement and rounding
  ang_t          ac;
  logic [ZW-1:0] z, h;
  logic [14:0]   hue_r;
  logic [15:0]   sat_r, int_r;

  always_comb begin
    ac = ca_r[6];
    if (ac[AW-1]) ac = '0;
    if (ac > RIGHT) ac = RIGHT;
    if (!sb_r[6].vneg && !sb_r[6].uneg) begin
      z = ZW'(ac);
    end else if (sb_r[6].vneg && !sb_r[6].uneg) begin
      z = HALFTN - ZW'(ac);
    end else if (sb_r[6].vneg) begin
      z = HALFTN + ZW'(ac);
    end else begin
      z = FULL - ZW'(ac);
    end
    if (z >= FULL) z = z - FULL;
    h = (z + HALF) >> SH;
    if (h >= GRAY) h = GRAY - ZW'(1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue_r <= sb_r[6].gray ? GRAY[14:0] : h[14:0];
      sat_r <= sb_r[6].gray ? 16'd0 : (cl_r[4] ? 16'hFFFF : qt_r[4]);
      int_r <= it_r[4];
    end
  end

  assign out_tdata = {1'b0, int_r, sat_r, hue_r};

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted request did not enter the pipeline");

  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NST-2] && adv && sb_r[6].gray |=> sat_r == 16'd0 && hue_r == GRAY[14:0])
    else $error("gray pixel gave nonzero saturation or a hue");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NST-1] && !out_tready |=> vld_r[NST-1] && $stable(hue_r) && $stable(sat_r))
    else $error("stalled result changed");

endmodule

@@ verif/rgb_to_hsi_convert_tb.sv @@
// self-checking testbench for the rgb to hsi pixel converter
`timescale 1ns / 100ps

module rgb_to_hsi_convert_tb;
  import rhc_pkg::*;

  localparam int unsigned HUE_FRAC = HUE_FRAC_DEF;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] intensity;
    logic [15:0] saturation;
    logic [14:0] hue;
  } hsi_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [23:0] in_tdata;    // red, green, blue
  logic out_tvalid;
  logic out_tready;
  logic [47:0] out_tdata;   // hue, saturation, intensity, zero

  hsi_t expected_hsi[$];
  int unsigned fail_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  longint unsigned cycle_count;

  const longint arctan_q16[18] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

  rgb_to_hsi_convert u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [14:0] hue_angle(longint v, longint u);
    longint x, y, dx, dy, ang, z, h;
    longint full;
    int unsigned sh;
    full = longint'(360) << 16;
    sh = 16 - HUE_FRAC;
    x = (v < 0 ? -v : v) * 65536;
    y = (u < 0 ? -u : u) * 113512;
    ang = 0;
    for (int i = 0; i < 18; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        ang = ang + arctan_q16[i];
      end else begin
        x = x - dx;
        y = y + dy;
        ang = ang - arctan_q16[i];
      end
    end
    if (ang < 0) ang = 0;
    if (ang > (longint'(90) << 16)) ang = longint'(90) << 16;
    if (v >= 0 && u >= 0) z = ang;
    else if (v < 0 && u >= 0) z = (longint'(180) << 16) - ang;
    else if (v < 0) z = (longint'(180) << 16) + ang;
    else z = full - ang;
    if (z >= full) z = z - full;
    h = (z + ((longint'(1) << sh) >> 1)) >> sh;
    if (h >= (longint'(360) << HUE_FRAC)) h = (longint'(360) << HUE_FRAC) - 1;
    return h[14:0];
  endfunction

  function automatic hsi_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    hsi_t res;
    longint sum, mx, mn, a1, b1, a2, b2, na, nb, sat, inten;
    sum = r + g + b;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    inten = (sum * 257 + 1) / 3;
    res.intensity = inten[15:0];
    if (mx == mn) begin
      res.hue = 15'(longint'(360) << HUE_FRAC);
      res.saturation = '0;
    end else begin
      a1 = 3 * mx - sum; b1 = 765 - sum;
      a2 = sum - 3 * mn; b2 = sum;
      if (a1 * b2 >= a2 * b1) begin
        na = a1; nb = b1;
      end else begin
        na = a2; nb = b2;
      end
      sat = (2 * 65535 * na + nb) / (2 * nb);
      if (sat > 65535) sat = 65535;
      res.saturation = sat[15:0];
      res.hue = hue_angle(2 * longint'(r) - g - b, longint'(g) - b);
    end
    return res;
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {b, g, r};
    do @(posedge clk); while (!in_tready);
    expected_hsi.push_back(convert_pixel(r, g, b));
    @(negedge clk);
  endtask

  task automatic test_directed();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd200, 8'd200, 8'd199);
    send_pixel(8'd0, 8'd1, 8'd1);
    send_pixel(8'd128, 8'd0, 8'd0);
    send_pixel(8'd170, 8'd85, 8'd85);
    send_pixel(8'd255, 8'd0, 8'd2);
    send_pixel(8'd10, 8'd20, 8'd30);
    send_pixel(8'd85, 8'd170, 8'd170);
  endtask

  task automatic test_random(input int unsigned count, input int unsigned idle_pct,
                             input int unsigned stall_pct);
    logic [7:0] r, g, b;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) begin
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      case ($urandom_range(9))
        0: begin
          g = r; b = r;
        end
        1: begin
          g = 8'(r + $urandom_range(2)); b = r;
        end
        2: begin
          r = $urandom_range(1) ? 8'd255 : 8'd0;
          b = $urandom_range(1) ? 8'd255 : 8'd0;
        end
        3: b = g;
        default: ;
      endcase
      send_pixel(r, g, b);
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    hsi_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[46:0];
      if (expected_hsi.size() == 0) begin
        $error("unexpected result request %h", out_tdata);
        fail_count++;
      end else begin
        want = expected_hsi.pop_front();
        if (got.hue !== want.hue) begin
          $error("hue expected %0d actual %0d", want.hue, got.hue);
          fail_count++;
        end
        if (got.saturation !== want.saturation) begin
          $error("saturation expected %0d actual %0d", want.saturation, got.saturation);
          fail_count++;
        end
        if (got.intensity !== want.intensity) begin
          $error("intensity expected %0d actual %0d", want.intensity, got.intensity);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    fail_count = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(410, 0, 0);
    test_random(410, 87, 0);
    test_random(410, 0, 87);
    test_random(410, 9, 9);
    in_tvalid = 1'b0;
    while (expected_hsi.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
